// File: hdl/mi3_pkg.sv
// Shared types and widths for the 3x3 matrix inverse unit.
// No dependencies; every other file in hdl imports this package.
package mi3_pkg;

    // Field widths and fixed-point scaling
    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;
    localparam int IN_FRAC  = 12;
    localparam int OUT_FRAC = 16;
    localparam int SCALE    = IN_FRAC + OUT_FRAC;

    // Exact internal widths
    localparam int PROD_W = 2 * IN_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int TERM_W = IN_W + COF_W;
    localparam int DET_W  = TERM_W + 2;
    localparam int NUM_W  = COF_W + SCALE;
    localparam int CMP_W  = DET_W + OUT_W;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SING = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [IN_W-1:0] m00;
        logic signed [IN_W-1:0] m01;
        logic signed [IN_W-1:0] m02;
        logic signed [IN_W-1:0] m10;
        logic signed [IN_W-1:0] m11;
        logic signed [IN_W-1:0] m12;
        logic signed [IN_W-1:0] m20;
        logic signed [IN_W-1:0] m21;
        logic signed [IN_W-1:0] m22;
    } mat_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] r00;
        logic signed [OUT_W-1:0] r01;
        logic signed [OUT_W-1:0] r02;
        logic signed [OUT_W-1:0] r10;
        logic signed [OUT_W-1:0] r11;
        logic signed [OUT_W-1:0] r12;
        logic signed [OUT_W-1:0] r20;
        logic signed [OUT_W-1:0] r21;
        logic signed [OUT_W-1:0] r22;
        logic [1:0]              status;
    } mat_out_t;

    typedef logic signed [COF_W-1:0] cof_t;
    typedef logic signed [DET_W-1:0] det_t;

    // One divider lane: partial remainder, quotient so far, sign, overflow
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [OUT_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } div_lane_t;

    typedef div_lane_t [8:0] lane_vec_t;

    // Control that travels with each item through the divider
    typedef struct packed {
        logic vld;
        logic sing;
    } div_ctl_t;

endpackage

// File: hdl/mi3_adjugate.sv
// Cofactors and determinant of a 3x3 matrix, four register stages.
// Depends on mi3_pkg.
module mi3_adjugate (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vld_in,
    input  mi3_pkg::mat_in_t mat,
    output logic             vld_out,
    output mi3_pkg::cof_t    cof [9],
    output mi3_pkg::det_t    det
);
    import mi3_pkg::*;

    logic [3:0]               vld_reg;
    logic signed [PROD_W-1:0] pa_next [9];
    logic signed [PROD_W-1:0] pb_next [9];
    logic signed [PROD_W-1:0] pa_reg  [9];
    logic signed [PROD_W-1:0] pb_reg  [9];
    logic signed [IN_W-1:0]   row_s1_reg [3];
    logic signed [IN_W-1:0]   row_s2_reg [3];
    cof_t                     cof_next [9];
    cof_t                     cof_s2_reg [9];
    cof_t                     cof_s3_reg [9];
    cof_t                     cof_s4_reg [9];
    logic signed [TERM_W-1:0] term_next [3];
    logic signed [TERM_W-1:0] term_reg  [3];
    det_t                     det_next;
    det_t                     det_reg;

    // Form the two products of each 2x2 minor
    always_comb
    begin
        pa_next[0] = mat.m11 * mat.m22;  pb_next[0] = mat.m12 * mat.m21;
        pa_next[1] = mat.m02 * mat.m21;  pb_next[1] = mat.m01 * mat.m22;
        pa_next[2] = mat.m01 * mat.m12;  pb_next[2] = mat.m02 * mat.m11;
        pa_next[3] = mat.m12 * mat.m20;  pb_next[3] = mat.m10 * mat.m22;
        pa_next[4] = mat.m00 * mat.m22;  pb_next[4] = mat.m02 * mat.m20;
        pa_next[5] = mat.m02 * mat.m10;  pb_next[5] = mat.m00 * mat.m12;
        pa_next[6] = mat.m10 * mat.m21;  pb_next[6] = mat.m11 * mat.m20;
        pa_next[7] = mat.m01 * mat.m20;  pb_next[7] = mat.m00 * mat.m21;
        pa_next[8] = mat.m00 * mat.m11;  pb_next[8] = mat.m01 * mat.m10;
    end

    // Subtract to signed cofactors
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            cof_next[i] = COF_W'(pa_reg[i]) - COF_W'(pb_reg[i]);
        end
    end

    // Expand along the first row
    always_comb
    begin
        term_next[0] = row_s2_reg[0] * cof_s2_reg[0];
        term_next[1] = row_s2_reg[1] * cof_s2_reg[3];
        term_next[2] = row_s2_reg[2] * cof_s2_reg[6];
        det_next     = DET_W'(term_reg[0]) + DET_W'(term_reg[1]) + DET_W'(term_reg[2]);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], vld_in};
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        pa_reg        <= pa_next;
        pb_reg        <= pb_next;
        row_s1_reg[0] <= mat.m00;
        row_s1_reg[1] <= mat.m01;
        row_s1_reg[2] <= mat.m02;
        row_s2_reg    <= row_s1_reg;
        cof_s2_reg    <= cof_next;
        cof_s3_reg    <= cof_s2_reg;
        cof_s4_reg    <= cof_s3_reg;
        term_reg      <= term_next;
        det_reg       <= det_next;
    end

    assign vld_out = vld_reg[3];
    assign cof     = cof_s4_reg;
    assign det     = det_reg;

endmodule

// File: hdl/mi3_prep.sv
// Magnitudes, signs, overflow test and divider seed, two register stages.
// Depends on mi3_pkg.
module mi3_prep (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     vld_in,
    input  mi3_pkg::cof_t            cof [9],
    input  mi3_pkg::det_t            det,
    output mi3_pkg::div_ctl_t        ctl,
    output mi3_pkg::lane_vec_t       lanes,
    output logic [mi3_pkg::DET_W-1:0] den
);
    import mi3_pkg::*;

    logic             vld_reg;
    logic             sing_reg;
    logic [COF_W-1:0] nmag_next [9];
    logic [COF_W-1:0] nmag_reg  [9];
    logic [8:0]       neg_next;
    logic [8:0]       neg_reg;
    logic [DET_W-1:0] dmag_next;
    logic [DET_W-1:0] dmag_reg;
    div_ctl_t         ctl_reg;
    lane_vec_t        lanes_next;
    lane_vec_t        lanes_reg;
    logic [DET_W-1:0] den_reg;
    logic [NUM_W-1:0] num;
    logic [CMP_W-1:0] lim;

    // Take magnitudes and result signs
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            nmag_next[i] = cof[i][COF_W-1] ? (~cof[i] + 1'b1) : cof[i];
            neg_next[i]  = cof[i][COF_W-1] ^ det[DET_W-1];
        end
        dmag_next = det[DET_W-1] ? (~det + 1'b1) : det;
    end

    // Scale numerators and flag quotients wider than OUT_W bits
    always_comb
    begin
        lim = {dmag_reg, {OUT_W{1'b0}}};
        num = '0;
        for (int i = 0; i < 9; i++)
        begin
            num               = {nmag_reg[i], {SCALE{1'b0}}};
            lanes_next[i].rem = num;
            lanes_next[i].quo = '0;
            lanes_next[i].neg = neg_reg[i];
            lanes_next[i].ovf = CMP_W'(num) >= lim;
        end
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            ctl_reg <= '0;
        end
        else
        begin
            vld_reg      <= vld_in;
            ctl_reg.vld  <= vld_reg;
            ctl_reg.sing <= sing_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        nmag_reg  <= nmag_next;
        neg_reg   <= neg_next;
        dmag_reg  <= dmag_next;
        sing_reg  <= (det == '0);
        lanes_reg <= lanes_next;
        den_reg   <= dmag_reg;
    end

    assign ctl   = ctl_reg;
    assign lanes = lanes_reg;
    assign den   = den_reg;

endmodule

// File: hdl/mi3_div_step.sv
// One restoring-division stage: resolves quotient bit BIT in all nine lanes.
// Depends on mi3_pkg.
module mi3_div_step #(
    parameter int BIT = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  mi3_pkg::div_ctl_t         ctl_in,
    input  mi3_pkg::lane_vec_t        lanes_in,
    input  logic [mi3_pkg::DET_W-1:0] den_in,
    output mi3_pkg::div_ctl_t         ctl_out,
    output mi3_pkg::lane_vec_t        lanes_out,
    output logic [mi3_pkg::DET_W-1:0] den_out
);
    import mi3_pkg::*;

    div_ctl_t         ctl_reg;
    lane_vec_t        lanes_next;
    lane_vec_t        lanes_reg;
    logic [DET_W-1:0] den_reg;
    logic [CMP_W-1:0] sub;
    logic [CMP_W-1:0] diff;

    // Trial subtract of the shifted divisor
    always_comb
    begin
        sub  = CMP_W'(den_in) << BIT;
        diff = '0;
        for (int i = 0; i < 9; i++)
        begin
            lanes_next[i] = lanes_in[i];
            diff          = CMP_W'(lanes_in[i].rem) - sub;
            if (CMP_W'(lanes_in[i].rem) >= sub)
            begin
                lanes_next[i].rem = diff[NUM_W-1:0];
                lanes_next[i].quo = lanes_in[i].quo | (OUT_W'(1) << BIT);
            end
        end
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        lanes_reg <= lanes_next;
        den_reg   <= den_in;
    end

    assign ctl_out   = ctl_reg;
    assign lanes_out = lanes_reg;
    assign den_out   = den_reg;

endmodule

// File: hdl/matrix_inverse_3x3_unit.sv
// 3x3 matrix inverse by adjugate over determinant, Q4.12 in, Q16.16 out.
// The divider has one register stage per quotient bit, most significant bit first.
// Throughput: one item per cycle; busy stays low and results cannot be held off.
// Reset clears only the valid bits and the control words that carry them; no item is in flight after reset.
// Depends on mi3_pkg, mi3_adjugate, mi3_prep, mi3_div_step.
module matrix_inverse_3x3_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mi3_pkg::mat_in_t  matrix,
    output logic              done,
    output mi3_pkg::mat_out_t result
);
    import mi3_pkg::*;

    localparam logic [OUT_W-1:0] NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};

    logic             adj_vld;
    cof_t             adj_cof [9];
    det_t             adj_det;
    div_ctl_t         ctl_s   [OUT_W+1];
    lane_vec_t        lanes_s [OUT_W+1];
    logic [DET_W-1:0] den_s   [OUT_W+1];
    logic [OUT_W-1:0] elem    [9];
    logic [8:0]       sat;
    mat_out_t         result_next;
    mat_out_t         result_reg;
    logic             done_reg;

    assign busy = 1'b0;

    mi3_adjugate u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (start),
        .mat     (matrix),
        .vld_out (adj_vld),
        .cof     (adj_cof),
        .det     (adj_det)
    );

    mi3_prep u_prep (
        .clk    (clk),
        .rst_n  (rst_n),
        .vld_in (adj_vld),
        .cof    (adj_cof),
        .det    (adj_det),
        .ctl    (ctl_s[0]),
        .lanes  (lanes_s[0]),
        .den    (den_s[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar s = 0; s < OUT_W; s++)
    begin : g_div
        mi3_div_step #(
            .BIT (OUT_W - 1 - s)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (ctl_s[s]),
            .lanes_in  (lanes_s[s]),
            .den_in    (den_s[s]),
            .ctl_out   (ctl_s[s+1]),
            .lanes_out (lanes_s[s+1]),
            .den_out   (den_s[s+1])
        );
    end

    // Apply signs, saturate or zero singular items, and pack the item with its status
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            sat[i] = lanes_s[OUT_W][i].ovf ||
                     (lanes_s[OUT_W][i].neg ? (lanes_s[OUT_W][i].quo > NEG_LIM)
                                            : lanes_s[OUT_W][i].quo[OUT_W-1]);
            if (ctl_s[OUT_W].sing)
            begin
                elem[i] = '0;
            end
            else if (sat[i])
            begin
                elem[i] = lanes_s[OUT_W][i].neg ? NEG_LIM : POS_LIM;
            end
            else if (lanes_s[OUT_W][i].neg)
            begin
                elem[i] = ~lanes_s[OUT_W][i].quo + 1'b1;
            end
            else
            begin
                elem[i] = lanes_s[OUT_W][i].quo;
            end
        end
        result_next.r00 = elem[0];
        result_next.r01 = elem[1];
        result_next.r02 = elem[2];
        result_next.r10 = elem[3];
        result_next.r11 = elem[4];
        result_next.r12 = elem[5];
        result_next.r20 = elem[6];
        result_next.r21 = elem[7];
        result_next.r22 = elem[8];
        if (ctl_s[OUT_W].sing)
        begin
            result_next.status = ST_SING;
        end
        else if (|sat)
        begin
            result_next.status = ST_SAT;
        end
        else
        begin
            result_next.status = ST_OK;
        end
    end

    // Hold the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_s[OUT_W].vld;
        end
    end

    // Hold the result item
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(OUT_W + 7) done)
        else $error("accepted item did not complete on time");

    a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, OUT_W + 7))
        else $error("result strobe without an accepted item");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_SING) |->
        (result.r00 == 0 && result.r11 == 0 && result.r22 == 0 &&
         result.r01 == 0 && result.r12 == 0 && result.r20 == 0))
        else $error("singular item with nonzero elements");
`endif

endmodule
